// ----- design/xoodoo_permutation_macros.svh -----
// ---------------------------------------------------------------------------
// Xoodoo permutation assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef XOODOO_PERMUTATION_MACROS_SVH
`define XOODOO_PERMUTATION_MACROS_SVH

// Same-cycle implication
`define XD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("xoodoo_permutation: same-cycle check failed");

// Next-cycle implication
`define XD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("xoodoo_permutation: next-cycle check failed");

`endif

// ----- design/xoodoo_pkg.sv -----
// ---------------------------------------------------------------------------
// Xoodoo package
// State type, round constants and the single-round function.
// ---------------------------------------------------------------------------
`default_nettype none

package xoodoo_pkg;

    localparam int XD_ROUNDS = 12;
    localparam int XD_LANES  = 12;
    localparam int LANE_W    = 32;

    typedef logic [XD_LANES-1:0][LANE_W-1:0] state_t;
    typedef logic [LANE_W-1:0]               lane_t;

    localparam lane_t XD_RC [XD_ROUNDS] = '{
        32'h0000_0058, 32'h0000_0038, 32'h0000_03C0, 32'h0000_00D0,
        32'h0000_0120, 32'h0000_0014, 32'h0000_0060, 32'h0000_002C,
        32'h0000_0380, 32'h0000_00F0, 32'h0000_01A0, 32'h0000_0012
    };

    function automatic lane_t xd_rotl(lane_t v, int r);
        lane_t res;
        res = (v << r) | (v >> (LANE_W - r));
        return res;
    endfunction

    function automatic state_t xd_round(state_t a_in, lane_t rc);
        state_t a;
        state_t t;
        lane_t  par [4];
        lane_t  eff [4];
        a = a_in;
        // theta
        for (int c = 0; c < 4; c++)
        begin
            par[c] = a[c] ^ a[4 + c] ^ a[8 + c];
        end
        for (int c = 0; c < 4; c++)
        begin
            eff[c] = xd_rotl(par[(c + 3) & 3], 5) ^ xd_rotl(par[(c + 3) & 3], 14);
        end
        for (int c = 0; c < 4; c++)
        begin
            a[c]     = a[c]     ^ eff[c];
            a[4 + c] = a[4 + c] ^ eff[c];
            a[8 + c] = a[8 + c] ^ eff[c];
        end
        // rho-west
        for (int c = 0; c < 4; c++)
        begin
            t[c]     = a[c];
            t[4 + c] = a[4 + ((c + 3) & 3)];
            t[8 + c] = xd_rotl(a[8 + c], 11);
        end
        // iota
        t[0] = t[0] ^ rc;
        // chi
        for (int c = 0; c < 4; c++)
        begin
            a[c]     = t[c]     ^ (~t[4 + c] & t[8 + c]);
            a[4 + c] = t[4 + c] ^ (~t[8 + c] & t[c]);
            a[8 + c] = t[8 + c] ^ (~t[c]     & t[4 + c]);
        end
        // rho-east
        for (int c = 0; c < 4; c++)
        begin
            t[c]     = a[c];
            t[4 + c] = xd_rotl(a[4 + c], 1);
            t[8 + c] = xd_rotl(a[8 + ((c + 2) & 3)], 8);
        end
        return t;
    endfunction

endpackage

`default_nettype wire

// ----- design/xoodoo_permutation.sv -----
// Each input state passes through the stage registers in order, one round per stage.
// Throughput: one 384-bit state per cycle while the output is not stalled; twelve round stages run back to back.
// Each stage holds its state while the stage after it is full and stalled;
// empty stages fill in behind a stalled output.
// Reset: rst_n clears all stage valid bits asynchronously; data is not reset.
// ---------------------------------------------------------------------------
// Xoodoo permutation, 384-bit state, 12 rounds
// Twelve-stage pipeline, one Xoodoo round in front of each stage register.
// ---------------------------------------------------------------------------
`default_nettype none

`include "xoodoo_permutation_macros.svh"

module xoodoo_permutation
    import xoodoo_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // lane_0 .. lane_11, 32 bits each, lane_0 in bits 31:0
    input  wire logic [383:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // result_0 .. result_11, 32 bits each, result_0 in bits 31:0
    output logic [383:0]      m_axis_tdata
);

    state_t                 data_reg   [XD_ROUNDS];
    state_t                 data_next  [XD_ROUNDS];
    logic   [XD_ROUNDS-1:0] valid_reg;
    logic   [XD_ROUNDS-1:0] valid_next;
    logic   [XD_ROUNDS-1:0] stage_ready;

    assign stage_ready[XD_ROUNDS-1] = !valid_reg[XD_ROUNDS-1] || m_axis_tready;

    genvar gi;
    generate
        for (gi = 0; gi < XD_ROUNDS - 1; gi++)
        begin : g_ready
            assign stage_ready[gi] = !valid_reg[gi] || stage_ready[gi + 1];
        end

        for (gi = 0; gi < XD_ROUNDS; gi++)
        begin : g_stage
            if (gi == 0)
            begin : g_first
                assign data_next[gi]  = xd_round(state_t'(s_axis_tdata), XD_RC[gi]);
                assign valid_next[gi] = stage_ready[gi] ? s_axis_tvalid : valid_reg[gi];
            end
            else
            begin : g_rest
                assign data_next[gi]  = xd_round(data_reg[gi - 1], XD_RC[gi]);
                assign valid_next[gi] = stage_ready[gi] ? valid_reg[gi - 1] : valid_reg[gi];
            end

            always_ff @(posedge clk)
            begin
                if (stage_ready[gi])
                begin
                    data_reg[gi] <= data_next[gi];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign s_axis_tready = stage_ready[0];
    assign m_axis_tvalid = valid_reg[XD_ROUNDS-1];
    assign m_axis_tdata  = data_reg[XD_ROUNDS-1];

    `XD_ASSERT_NEXT(a_accept_fills, s_axis_tvalid && s_axis_tready, valid_reg[0])
    `XD_ASSERT_NEXT(a_last_move, valid_reg[XD_ROUNDS-2] && stage_ready[XD_ROUNDS-1], m_axis_tvalid)
    `XD_ASSERT_NOW(a_full_blocks, (&valid_reg) && !m_axis_tready, !s_axis_tready)

endmodule

`default_nettype wire
